FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the stream decoder.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset
`define AST_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Condition must never be true at a clock edge outside reset
`define AST_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define AST_ALWAYS(lbl, clk, rstn, prop)
`define AST_NEVER(lbl, clk, rstn, cond)

`endif

`endif

FILE: rtl/msgpd_pkg.sv
// Package for the MessagePack stream decoder: type codes, result codes,
// the result record and the value extension helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msgpd_pkg;

  // Leading byte codes and ranges
  localparam logic [7:0] PFIXINT_HI  = 8'h7f;
  localparam logic [7:0] FIXMAP_HI   = 8'h8f;
  localparam logic [7:0] FIXARR_HI   = 8'h9f;
  localparam logic [7:0] FIXSTR_HI   = 8'hbf;
  localparam logic [7:0] FIXSTR_MASK = 8'h1f;
  localparam logic [7:0] CODE_NIL    = 8'hc0;
  localparam logic [7:0] CODE_FALSE  = 8'hc2;
  localparam logic [7:0] CODE_TRUE   = 8'hc3;
  localparam logic [7:0] CODE_BIN8   = 8'hc4;
  localparam logic [7:0] CODE_BIN32  = 8'hc6;
  localparam logic [7:0] CODE_UINT8  = 8'hcc;
  localparam logic [7:0] CODE_UINT64 = 8'hcf;
  localparam logic [7:0] CODE_INT8   = 8'hd0;
  localparam logic [7:0] CODE_INT64  = 8'hd3;
  localparam logic [7:0] CODE_STR8   = 8'hd9;
  localparam logic [7:0] CODE_STR32  = 8'hdb;
  localparam logic [7:0] NFIXINT_LO  = 8'he0;

  // Result kinds
  localparam logic [1:0] KIND_VALUE   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Type tags
  localparam logic [3:0] TAG_NIL    = 4'd0;
  localparam logic [3:0] TAG_FALSE  = 4'd1;
  localparam logic [3:0] TAG_TRUE   = 4'd2;
  localparam logic [3:0] TAG_FIXINT = 4'd3;
  localparam logic [1:0] TAG_UINT_HI = 2'b01;
  localparam logic [1:0] TAG_SINT_HI = 2'b10;
  localparam logic [3:0] TAG_STR    = 4'd12;
  localparam logic [3:0] TAG_BIN    = 4'd13;

  // Error codes
  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_UNSUPPORTED = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  tag;
    logic [63:0] value;
    logic [7:0]  payload;
    logic        done;
    logic [1:0]  err;
  } res_t;

  // Byte count 1, 2, 4 or 8 from its log2
  function automatic logic [3:0] nbytes_of(logic [1:0] lg);
    nbytes_of = 4'd1 << lg;
  endfunction

  // Keep the low 1, 2, 4 or 8 bytes, sign- or zero-extended
  function automatic logic [63:0] ext_value(logic [63:0] a, logic [1:0] lg,
                                            logic sgn);
    logic [63:0] r;
    r = a;
    unique case (lg)
      2'd0: r = {{56{sgn & a[7]}}, a[7:0]};
      2'd1: r = {{48{sgn & a[15]}}, a[15:0]};
      2'd2: r = {{32{sgn & a[31]}}, a[31:0]};
      2'd3: r = a;
      default: r = a;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/msgpack_stream_decoder.sv
// MessagePack stream decoder, top level. Uses msgpd_pkg and the assertion
// macros in assert_macros.svh.
//
// Decodes a MessagePack byte stream at one byte per clock cycle while the
// skid entry is free. A byte is accepted in any cycle in which the two-entry
// output stage (result register plus skid register) has its skid entry free,
// so the input keeps flowing while a stalled output holds the result register.
// Each byte is decoded by one level of logic against the parser state; its
// result, if any, goes into the result register, or into the skid register
// while the output stalls. Scalars give one value result on their last byte;
// str and bin give a header result with the length, then one result per payload
// byte. Unsupported codes give an error-only result; a value left unfinished at
// a byte marked final is flagged as truncated and the parser returns to idle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module msgpack_stream_decoder
  import msgpd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        final_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       result_kind_o,
  output logic [3:0]       type_tag_o,
  output logic [63:0]      value_bits_o,
  output logic [7:0]       payload_byte_o,
  output logic             value_done_o,
  output logic [1:0]       error_code_o
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_COLLECT = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [3:0]  tag_q, tag_d;
  logic        len_mode_q, len_mode_d;
  logic [3:0]  bytes_left_q, bytes_left_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] pay_left_q, pay_left_d;

  res_t        res;
  logic        has_res;
  res_t        out_q, skid_q;
  logic        out_valid_q, skid_valid_q;
  logic        in_fire, out_fire;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // Decode one byte against the parser state
  always_comb begin
    logic [63:0] acc_sh;
    logic [3:0]  bl_dec;
    logic [31:0] pl_dec;
    logic [31:0] len;
    logic [7:0]  b;
    b            = data_byte_i;
    acc_sh       = {acc_q[55:0], b};
    bl_dec       = bytes_left_q - 4'd1;
    pl_dec       = pay_left_q - 32'd1;
    len          = 32'd0;
    phase_d      = phase_q;
    tag_d        = tag_q;
    len_mode_d   = len_mode_q;
    bytes_left_d = bytes_left_q;
    acc_d        = acc_q;
    pay_left_d   = pay_left_q;
    has_res      = 1'b0;
    res          = '{kind: KIND_VALUE, tag: TAG_NIL, value: 64'd0, payload: 8'd0,
                     done: 1'b1, err: ERR_NONE};

    unique case (phase_q)
      PH_COLLECT: begin
        // Shift in the next big-endian byte
        acc_d        = acc_sh;
        bytes_left_d = bl_dec;
        if (bl_dec == 4'd0) begin
          has_res = 1'b1;
          res.tag = tag_q;
          if (len_mode_q) begin
            len        = acc_sh[31:0];
            pay_left_d = len;
            phase_d    = (len != 32'd0) ? PH_PAYLOAD : PH_IDLE;
            res.value  = {32'd0, len};
            res.done   = (len == 32'd0);
          end else begin
            phase_d   = PH_IDLE;
            res.value = ext_value(acc_sh, tag_q[1:0], tag_q[3]);
          end
        end
      end
      PH_PAYLOAD: begin
        // Pass one payload byte
        pay_left_d  = pl_dec;
        has_res     = 1'b1;
        res.kind    = KIND_PAYLOAD;
        res.tag     = tag_q;
        res.payload = b;
        res.done    = (pl_dec == 32'd0);
        if (pl_dec == 32'd0) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        // Idle: classify the type code
        phase_d = PH_IDLE;
        has_res = 1'b1;
        priority if (b <= PFIXINT_HI || b >= NFIXINT_LO) begin
          res.tag   = TAG_FIXINT;
          res.value = ext_value({56'd0, b}, 2'd0, 1'b1);
        end else if (b <= FIXARR_HI) begin
          res.kind = KIND_ERROR;
          res.err  = ERR_UNSUPPORTED;
        end else if (b <= FIXSTR_HI) begin
          len        = {24'd0, b & FIXSTR_MASK};
          tag_d      = TAG_STR;
          pay_left_d = len;
          phase_d    = (len != 32'd0) ? PH_PAYLOAD : PH_IDLE;
          res.tag    = TAG_STR;
          res.value  = {32'd0, len};
          res.done   = (len == 32'd0);
        end else if (b == CODE_NIL) begin
          res.tag = TAG_NIL;
        end else if (b == CODE_FALSE) begin
          res.tag = TAG_FALSE;
        end else if (b == CODE_TRUE) begin
          res.tag   = TAG_TRUE;
          res.value = 64'd1;
        end else if (b >= CODE_BIN8 && b <= CODE_BIN32) begin
          has_res      = 1'b0;
          phase_d      = PH_COLLECT;
          tag_d        = TAG_BIN;
          len_mode_d   = 1'b1;
          bytes_left_d = nbytes_of(b[1:0]);
          acc_d        = 64'd0;
        end else if (b >= CODE_UINT8 && b <= CODE_UINT64) begin
          has_res      = 1'b0;
          phase_d      = PH_COLLECT;
          tag_d        = {TAG_UINT_HI, b[1:0]};
          len_mode_d   = 1'b0;
          bytes_left_d = nbytes_of(b[1:0]);
          acc_d        = 64'd0;
        end else if (b >= CODE_INT8 && b <= CODE_INT64) begin
          has_res      = 1'b0;
          phase_d      = PH_COLLECT;
          tag_d        = {TAG_SINT_HI, b[1:0]};
          len_mode_d   = 1'b0;
          bytes_left_d = nbytes_of(b[1:0]);
          acc_d        = 64'd0;
        end else if (b >= CODE_STR8 && b <= CODE_STR32) begin
          has_res      = 1'b0;
          phase_d      = PH_COLLECT;
          tag_d        = TAG_STR;
          len_mode_d   = 1'b1;
          bytes_left_d = nbytes_of(b[1:0] - 2'd1);
          acc_d        = 64'd0;
        end else begin
          res.kind = KIND_ERROR;
          res.err  = ERR_UNSUPPORTED;
        end
      end
    endcase

    // Flag an unfinished value at the end of the buffer and drop back to idle
    if (final_byte_i) begin
      if (phase_d != PH_IDLE) begin
        if (has_res) begin
          res.done = 1'b1;
          res.err  = ERR_TRUNCATED;
        end else begin
          has_res = 1'b1;
          res     = '{kind: KIND_ERROR, tag: tag_d, value: 64'd0, payload: 8'd0,
                      done: 1'b1, err: ERR_TRUNCATED};
        end
      end
      phase_d      = PH_IDLE;
      len_mode_d   = 1'b0;
      bytes_left_d = 4'd0;
      pay_left_d   = 32'd0;
    end
  end

  // Advance the parser state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      tag_q        <= 4'd0;
      len_mode_q   <= 1'b0;
      bytes_left_q <= 4'd0;
      acc_q        <= 64'd0;
      pay_left_q   <= 32'd0;
    end else if (in_fire) begin
      phase_q      <= phase_d;
      tag_q        <= tag_d;
      len_mode_q   <= len_mode_d;
      bytes_left_q <= bytes_left_d;
      acc_q        <= acc_d;
      pay_left_q   <= pay_left_d;
    end
  end

  // Output register with skid entry: hold a result while the output stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire && has_res) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire && has_res) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_q.kind;
  assign type_tag_o     = out_q.tag;
  assign value_bits_o   = out_q.value;
  assign payload_byte_o = out_q.payload;
  assign value_done_o   = out_q.done;
  assign error_code_o   = out_q.err;

  // Checks on the parser and the output stage
  `AST_NEVER(a_skid_without_out, clk_i, rst_ni, skid_valid_q && !out_valid_q)
  `AST_NEVER(a_collect_no_bytes, clk_i, rst_ni,
             phase_q == PH_COLLECT && bytes_left_q == 4'd0)
  `AST_NEVER(a_payload_no_bytes, clk_i, rst_ni,
             phase_q == PH_PAYLOAD && pay_left_q == 32'd0)
  `AST_ALWAYS(a_final_to_idle, clk_i, rst_ni,
              (in_fire && final_byte_i) |=> (phase_q == PH_IDLE))
  `AST_ALWAYS(a_error_ends_value, clk_i, rst_ni,
              (out_valid_q && out_q.err != ERR_NONE) |-> out_q.done)

endmodule

`default_nettype wire
